FILE: src/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg: shared constants for the camera ray direction unit
// Fixed-point widths of every pipeline quantity and configuration indexes.
// ----------------------------------------------------------------------------
package crd_pkg;

  // Fixed field widths
  localparam int COORD_W = 16;   // screen coordinate, Q0.16
  localparam int COMP_W  = 16;   // basis component, Q2.13
  localparam int VEC_W   = 3 * COMP_W;
  localparam int EXT_W   = 16;   // extent, Q4.12
  localparam int DIR_W   = 16;   // result component, Q1.14

  // Internal widths
  localparam int OFS_W   = 34;   // h, v offsets (Q.28)
  localparam int C_W     = 50;   // summed component (Q.41)
  localparam int MAG_W   = 49;   // component magnitude
  localparam int M_W     = 30;   // magnitude after normalizing shift
  localparam int K_W     = 5;    // normalizing shift amount
  localparam int SQ_W    = 62;   // sum of squares
  localparam int LEN_W   = 31;   // vector length
  localparam int FRAC_W  = 14;   // fraction bits of the result
  localparam int NUM_W   = 45;   // dividend m*2^14 + len/2
  localparam int Q_W     = 15;   // quotient bits
  localparam int FWD_SHIFT = 28; // weight of the forward axis

  localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(16384);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_W   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_H   = 3'd4;

  // Reset values
  localparam logic [VEC_W-1:0] RST_RIGHT   = 48'd8192;
  localparam logic [VEC_W-1:0] RST_UP      = 48'd536870912;
  localparam logic [VEC_W-1:0] RST_FORWARD = 48'd35184372088832;
  localparam logic [EXT_W-1:0] RST_EXTENT  = 16'd4096;

endpackage

FILE: src/camera_ray_direction_unit.sv
// ----------------------------------------------------------------------------
// camera_ray_direction_unit: pinhole camera ray generation
// Maps a screen position to right*h + up*v + forward and normalizes it to a
// unit direction in Q1.14.
//
//   channel  ports                                        direction
//   in       in_valid, in_stall, in_screen_x/y            into block
//   out      out_valid, out_stall, out_dir_x/y/z,          out of block
//            out_degenerate
//   cfg      cfg_we, cfg_index, cfg_wdata                 into block
//
// One transaction per cycle is accepted while the pipeline advances; it has
// 8 front stages, 31 square-root stages, 1 setup, 15 divide stages, output.
// The whole pipeline advances together; a stalled output freezes every stage.
// Reset clears all stage valid bits and loads the default camera basis.
// ----------------------------------------------------------------------------
module camera_ray_direction_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [crd_pkg::COORD_W-1:0]        in_screen_x,
  input  logic [crd_pkg::COORD_W-1:0]        in_screen_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [crd_pkg::DIR_W-1:0]   out_dir_x,
  output logic signed [crd_pkg::DIR_W-1:0]   out_dir_y,
  output logic signed [crd_pkg::DIR_W-1:0]   out_dir_z,
  output logic                               out_degenerate,
  input  logic                               cfg_we,
  input  logic [crd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crd_pkg::VEC_W-1:0]          cfg_wdata
);

  localparam int CW    = crd_pkg::COMP_W;
  localparam int SIDE1 = 1 + 3 + 3 * crd_pkg::M_W;

  // Configuration registers
  logic [crd_pkg::VEC_W-1:0] right_r, up_r, fwd_r;
  logic [crd_pkg::EXT_W-1:0] half_w_r, half_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_r  <= crd_pkg::RST_RIGHT;
      up_r     <= crd_pkg::RST_UP;
      fwd_r    <= crd_pkg::RST_FORWARD;
      half_w_r <= crd_pkg::RST_EXTENT;
      half_h_r <= crd_pkg::RST_EXTENT;
    end else if (cfg_we) begin
      case (cfg_index)
        crd_pkg::CFG_RIGHT:   right_r  <= cfg_wdata;
        crd_pkg::CFG_UP:      up_r     <= cfg_wdata;
        crd_pkg::CFG_FORWARD: fwd_r    <= cfg_wdata;
        crd_pkg::CFG_HALF_W:  half_w_r <= cfg_wdata[crd_pkg::EXT_W-1:0];
        crd_pkg::CFG_HALF_H:  half_h_r <= cfg_wdata[crd_pkg::EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the output register is free or being emptied
  logic advance;
  logic out_valid_r;
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // Stage 1: screen offsets h and v
  logic signed [17:0] sx, sy;
  logic signed [35:0] h_full, v_full;
  logic signed [crd_pkg::OFS_W-1:0] h_r, v_r;
  logic v1_r;

  always_comb begin
    sx     = $signed({1'b0, in_screen_x, 1'b0}) - 18'sd65536;
    sy     = 18'sd65536 - $signed({1'b0, in_screen_y, 1'b0});
    h_full = 36'($signed({1'b0, half_w_r})) * 36'(sx);
    v_full = 36'($signed({1'b0, half_h_r})) * 36'(sy);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      h_r <= h_full[crd_pkg::OFS_W-1:0];
      v_r <= v_full[crd_pkg::OFS_W-1:0];
    end
  end

  // Stages 2 to 4 per component: products, sum, magnitude
  logic signed [crd_pkg::C_W-1:0]   pr_r [3];
  logic signed [crd_pkg::C_W-1:0]   pu_r [3];
  logic signed [crd_pkg::C_W-1:0]   c_r  [3];
  logic        [crd_pkg::MAG_W-1:0] mag4_r [3];
  logic                             sgn4_r [3];
  logic v2_r, v3_r, v4_r;

  for (genvar i = 0; i < 3; i++) begin : g_comp
    logic signed [CW-1:0]            rc, uc, fc;
    logic signed [crd_pkg::C_W-1:0]  pr_nxt, pu_nxt, c_nxt, cabs;
    always_comb begin
      rc     = $signed(right_r[CW*i +: CW]);
      uc     = $signed(up_r[CW*i +: CW]);
      fc     = $signed(fwd_r[CW*i +: CW]);
      pr_nxt = crd_pkg::C_W'(rc) * crd_pkg::C_W'(h_r);
      pu_nxt = crd_pkg::C_W'(uc) * crd_pkg::C_W'(v_r);
      c_nxt  = pr_r[i] + pu_r[i] + (crd_pkg::C_W'(fc) <<< crd_pkg::FWD_SHIFT);
      cabs   = c_r[i][crd_pkg::C_W-1] ? -c_r[i] : c_r[i];
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        pr_r[i]   <= pr_nxt;
        pu_r[i]   <= pu_nxt;
        c_r[i]    <= c_nxt;
        mag4_r[i] <= cabs[crd_pkg::MAG_W-1:0];
        sgn4_r[i] <= c_r[i][crd_pkg::C_W-1];
      end
    end
  end

  // Stage 5: normalizing shift from the highest set bit of all magnitudes
  logic [crd_pkg::MAG_W-1:0] mag_or;
  logic [crd_pkg::K_W-1:0]   k_nxt, k5_r;
  logic [crd_pkg::MAG_W-1:0] mag5_r [3];
  logic [2:0]                sgn5_r;
  logic                      zero5_r;
  logic v5_r;

  always_comb begin
    mag_or = mag4_r[0] | mag4_r[1] | mag4_r[2];
    k_nxt  = '0;
    for (int b = crd_pkg::M_W; b < crd_pkg::MAG_W; b++) begin
      if (mag_or[b]) k_nxt = crd_pkg::K_W'(b - crd_pkg::M_W + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      k5_r    <= k_nxt;
      mag5_r  <= mag4_r;
      sgn5_r  <= {sgn4_r[2], sgn4_r[1], sgn4_r[0]};
      zero5_r <= (mag_or == '0);
    end
  end

  // Stages 6 to 8: shift, square, sum
  logic [crd_pkg::M_W-1:0]    m6_r [3];
  logic [crd_pkg::M_W-1:0]    m7_r [3];
  logic [crd_pkg::M_W-1:0]    m8_r [3];
  logic [2*crd_pkg::M_W-1:0]  sq7_r [3];
  logic [crd_pkg::SQ_W-1:0]   sum8_r;
  logic [2:0]                 sgn6_r, sgn7_r, sgn8_r;
  logic                       zero6_r, zero7_r, zero8_r;
  logic v6_r, v7_r, v8_r;

  for (genvar i = 0; i < 3; i++) begin : g_norm
    logic [crd_pkg::MAG_W-1:0] shifted;
    assign shifted = mag5_r[i] >> k5_r;
    always_ff @(posedge clk) begin
      if (advance) begin
        m6_r[i]  <= shifted[crd_pkg::M_W-1:0];
        sq7_r[i] <= m6_r[i] * m6_r[i];
        m7_r[i]  <= m6_r[i];
        m8_r[i]  <= m7_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sgn6_r  <= sgn5_r;
      sgn7_r  <= sgn6_r;
      sgn8_r  <= sgn7_r;
      zero6_r <= zero5_r;
      zero7_r <= zero6_r;
      zero8_r <= zero7_r;
      sum8_r  <= crd_pkg::SQ_W'(sq7_r[0]) + crd_pkg::SQ_W'(sq7_r[1])
               + crd_pkg::SQ_W'(sq7_r[2]);
    end
  end

  // Square root of the sum of squares
  logic                        sq_valid;
  logic [crd_pkg::LEN_W-1:0]   root;
  logic [SIDE1-1:0]            side_out;

  crd_isqrt #(.SIDE_W(SIDE1)) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .valid_i (v8_r),
    .n_i     (sum8_r),
    .side_i  ({zero8_r, sgn8_r, m8_r[2], m8_r[1], m8_r[0]}),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (side_out)
  );

  // Setup stage: guard the length and form rounded dividends
  logic [crd_pkg::LEN_W-1:0] len_r;
  logic [crd_pkg::NUM_W-1:0] num_r [3];
  logic [2:0]                sgn9_r;
  logic                      zero9_r;
  logic                      v9_r;
  logic [crd_pkg::LEN_W-1:0] len_g;

  assign len_g = (root == '0) ? crd_pkg::LEN_W'(1) : root;

  for (genvar i = 0; i < 3; i++) begin : g_num
    always_ff @(posedge clk) begin
      if (advance) begin
        num_r[i] <= (crd_pkg::NUM_W'(side_out[crd_pkg::M_W*i +: crd_pkg::M_W])
                     << crd_pkg::FRAC_W) + crd_pkg::NUM_W'(len_g >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      len_r   <= len_g;
      sgn9_r  <= side_out[3*crd_pkg::M_W +: 3];
      zero9_r <= side_out[SIDE1-1];
    end
  end

  // Divide lanes
  logic                    dv_valid;
  logic [crd_pkg::Q_W-1:0] q0, q1, q2;
  logic [1:0]              side0;
  logic                    side1, side2;

  crd_div #(.SIDE_W(2)) u_div_x (
    .clk(clk), .rst_n(rst_n), .advance(advance), .valid_i(v9_r),
    .num_i(num_r[0]), .den_i(len_r), .side_i({zero9_r, sgn9_r[0]}),
    .valid_o(dv_valid), .quo_o(q0), .side_o(side0)
  );
  crd_div #(.SIDE_W(1)) u_div_y (
    .clk(clk), .rst_n(rst_n), .advance(advance), .valid_i(v9_r),
    .num_i(num_r[1]), .den_i(len_r), .side_i(sgn9_r[1]),
    .valid_o(), .quo_o(q1), .side_o(side1)
  );
  crd_div #(.SIDE_W(1)) u_div_z (
    .clk(clk), .rst_n(rst_n), .advance(advance), .valid_i(v9_r),
    .num_i(num_r[2]), .den_i(len_r), .side_i(sgn9_r[2]),
    .valid_o(), .quo_o(q2), .side_o(side2)
  );

  // Output stage: clamp, apply sign, zero a degenerate ray
  function automatic logic signed [crd_pkg::DIR_W-1:0] to_dir(
    input logic [crd_pkg::Q_W-1:0] q, input logic neg, input logic zero);
    logic [crd_pkg::Q_W-1:0]   qc;
    logic [crd_pkg::DIR_W-1:0] qw;
    qc = (q > crd_pkg::ONE_Q14) ? crd_pkg::ONE_Q14 : q;
    qw = crd_pkg::DIR_W'(qc);
    if (zero) return '0;
    return neg ? $signed(-qw) : $signed(qw);
  endfunction

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dir_x      <= to_dir(q0, side0[0], side0[1]);
      out_dir_y      <= to_dir(q1, side1, side0[1]);
      out_dir_z      <= to_dir(q2, side2, side0[1]);
      out_degenerate <= side0[1];
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
      v9_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
      v9_r <= sq_valid;
      out_valid_r <= dv_valid;
    end
  end

  assign out_valid = out_valid_r;

  // A degenerate ray carries zero components
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_degenerate |->
      out_dir_x == '0 && out_dir_y == '0 && out_dir_z == '0)
    else $error("degenerate ray with nonzero components");

  // A proper ray has at least one nonzero component
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_degenerate |->
      out_dir_x != '0 || out_dir_y != '0 || out_dir_z != '0)
    else $error("normalized ray is all zero");

  // Components stay within unit magnitude
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      out_dir_x >= -16'sd16384 && out_dir_x <= 16'sd16384 &&
      out_dir_y >= -16'sd16384 && out_dir_y <= 16'sd16384 &&
      out_dir_z >= -16'sd16384 && out_dir_z <= 16'sd16384)
    else $error("ray component out of range");

  // A frozen pipeline keeps its output transaction
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> out_valid_r && $stable(out_dir_x) && $stable(out_degenerate))
    else $error("output changed while pipeline frozen");

endmodule

FILE: src/crd_isqrt.sv
// ----------------------------------------------------------------------------
// crd_isqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(n)); a side bus rides along.
// ----------------------------------------------------------------------------
module crd_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        valid_i,
  input  logic [crd_pkg::SQ_W-1:0]    n_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [crd_pkg::LEN_W-1:0]   root_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int STEPS = crd_pkg::LEN_W;
  localparam int SW    = crd_pkg::SQ_W;

  logic [SW-1:0]     n_r    [STEPS];
  logic [SW-1:0]     res_r  [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];
  logic              vld_r  [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (STEPS - 1 - s));
    logic [SW-1:0]     n_in;
    logic [SW-1:0]     res_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [SW:0]       trial;
    logic [SW-1:0]     n_nxt;
    logic [SW-1:0]     res_nxt;

    if (s == 0) begin : g_first
      assign n_in    = n_i;
      assign res_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign n_in    = n_r[s-1];
      assign res_in  = res_r[s-1];
      assign side_in = side_r[s-1];
      assign vld_in  = vld_r[s-1];
    end

    // Try the next root bit; keep it when the remainder allows
    always_comb begin
      trial = {1'b0, res_in} + {1'b0, BIT};
      if ({1'b0, n_in} >= trial) begin
        n_nxt   = SW'({1'b0, n_in} - trial);
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        n_nxt   = n_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (advance) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        n_r[s]    <= n_nxt;
        res_r[s]  <= res_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_r[STEPS-1];
  assign root_o  = res_r[STEPS-1][crd_pkg::LEN_W-1:0];
  assign side_o  = side_r[STEPS-1];

endmodule

FILE: src/crd_div.sv
// ----------------------------------------------------------------------------
// crd_div: pipelined restoring divider for one component
// One quotient bit per stage, most significant first; a side bus rides along.
// ----------------------------------------------------------------------------
module crd_div #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        valid_i,
  input  logic [crd_pkg::NUM_W-1:0]   num_i,
  input  logic [crd_pkg::LEN_W-1:0]   den_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [crd_pkg::Q_W-1:0]     quo_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int STEPS = crd_pkg::Q_W;
  localparam int NW    = crd_pkg::NUM_W;

  logic [NW-1:0]                rem_r  [STEPS];
  logic [crd_pkg::LEN_W-1:0]    den_r  [STEPS];
  logic [STEPS-1:0]             quo_r  [STEPS];
  logic [SIDE_W-1:0]            side_r [STEPS];
  logic                         vld_r  [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int SH = STEPS - 1 - s;
    logic [NW-1:0]             rem_in;
    logic [crd_pkg::LEN_W-1:0] den_in;
    logic [STEPS-1:0]          quo_in;
    logic [SIDE_W-1:0]         side_in;
    logic                      vld_in;
    logic [NW-1:0]             dsh;
    logic [NW-1:0]             rem_nxt;
    logic [STEPS-1:0]          quo_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign den_in  = den_r[s-1];
      assign quo_in  = quo_r[s-1];
      assign side_in = side_r[s-1];
      assign vld_in  = vld_r[s-1];
    end

    // Subtract the shifted divisor when it fits
    always_comb begin
      dsh     = NW'(den_in) << SH;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (rem_in >= dsh) begin
        rem_nxt     = rem_in - dsh;
        quo_nxt[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (advance) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem_r[s]  <= rem_nxt;
        den_r[s]  <= den_in;
        quo_r[s]  <= quo_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_r[STEPS-1];
  assign quo_o   = quo_r[STEPS-1];
  assign side_o  = side_r[STEPS-1];

endmodule

FILE: verif/ray_direction_checker.sv
// ----------------------------------------------------------------------------
// ray_direction_checker: scoreboard for the camera ray direction unit
// Tracks the camera configuration, predicts the unit ray for each accepted
// screen coordinate and compares every result transaction in order.
// ----------------------------------------------------------------------------
module ray_direction_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [crd_pkg::COORD_W-1:0]       in_screen_x,
  input  logic [crd_pkg::COORD_W-1:0]       in_screen_y,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [crd_pkg::DIR_W-1:0]  out_dir_x,
  input  logic signed [crd_pkg::DIR_W-1:0]  out_dir_y,
  input  logic signed [crd_pkg::DIR_W-1:0]  out_dir_z,
  input  logic                              out_degenerate,
  input  logic                              cfg_we,
  input  logic [crd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crd_pkg::VEC_W-1:0]         cfg_wdata,
  output int                                fail_count,
  output int                                rays_pending,
  output int                                rays_checked,
  output int                                degenerate_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [crd_pkg::DIR_W-1:0] dx;
    logic signed [crd_pkg::DIR_W-1:0] dy;
    logic signed [crd_pkg::DIR_W-1:0] dz;
    logic                             degen;
  } ray_t;

  logic [crd_pkg::VEC_W-1:0] cam_right, cam_up, cam_fwd;
  logic [crd_pkg::EXT_W-1:0] half_w, half_h;
  ray_t ray_queue[$];

  function automatic longint axis_comp(logic [crd_pkg::VEC_W-1:0] vec, int idx);
    logic signed [crd_pkg::COMP_W-1:0] c;
    c = vec[idx*crd_pkg::COMP_W +: crd_pkg::COMP_W];
    return longint'(c);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic ray_t predict_ray(logic [crd_pkg::COORD_W-1:0] sxi,
                                       logic [crd_pkg::COORD_W-1:0] syi);
    longint h, v;
    longint c[3];
    longint unsigned m[3];
    longint unsigned maxm, sumsq, len, q;
    int k;
    ray_t r;
    h = longint'(half_w) * (2 * longint'(sxi) - 65536);
    v = longint'(half_h) * (65536 - 2 * longint'(syi));
    maxm = 0;
    for (int i = 0; i < 3; i++) begin
      c[i] = axis_comp(cam_right, i) * h + axis_comp(cam_up, i) * v
           + axis_comp(cam_fwd, i) * (longint'(1) << crd_pkg::FWD_SHIFT);
      m[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
      if (m[i] > maxm) maxm = m[i];
    end
    r = '0;
    if (maxm == 0) begin
      r.degen = 1'b1;
      return r;
    end
    k = 0;
    while ((maxm >> k) >= (64'd1 << 30)) k++;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> k;
      sumsq += m[i] * m[i];
    end
    len = int_sqrt(sumsq);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      c[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
    r.dx = c[0][crd_pkg::DIR_W-1:0];
    r.dy = c[1][crd_pkg::DIR_W-1:0];
    r.dz = c[2][crd_pkg::DIR_W-1:0];
    return r;
  endfunction

  // Track configuration, queue predictions, check results
  always @(posedge clk) begin
    ray_t exp_ray;
    if (!rst_n) begin
      cam_right = crd_pkg::RST_RIGHT;
      cam_up    = crd_pkg::RST_UP;
      cam_fwd   = crd_pkg::RST_FORWARD;
      half_w    = crd_pkg::RST_EXTENT;
      half_h    = crd_pkg::RST_EXTENT;
      ray_queue.delete();
      fail_count = 0;
      rays_pending = 0;
      rays_checked = 0;
      degenerate_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          crd_pkg::CFG_RIGHT:   cam_right = cfg_wdata;
          crd_pkg::CFG_UP:      cam_up = cfg_wdata;
          crd_pkg::CFG_FORWARD: cam_fwd = cfg_wdata;
          crd_pkg::CFG_HALF_W:  half_w = cfg_wdata[crd_pkg::EXT_W-1:0];
          crd_pkg::CFG_HALF_H:  half_h = cfg_wdata[crd_pkg::EXT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        ray_queue.push_back(predict_ray(in_screen_x, in_screen_y));
      if (out_valid && !out_stall) begin
        if (ray_queue.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          exp_ray = ray_queue.pop_front();
          rays_checked++;
          if (exp_ray.degen) degenerate_seen++;
          if (out_dir_x !== exp_ray.dx) begin
            $error("dir_x: expected %0d, got %0d", exp_ray.dx, out_dir_x);
            fail_count++;
          end
          if (out_dir_y !== exp_ray.dy) begin
            $error("dir_y: expected %0d, got %0d", exp_ray.dy, out_dir_y);
            fail_count++;
          end
          if (out_dir_z !== exp_ray.dz) begin
            $error("dir_z: expected %0d, got %0d", exp_ray.dz, out_dir_z);
            fail_count++;
          end
          if (out_degenerate !== exp_ray.degen) begin
            $error("degenerate: expected %0b, got %0b", exp_ray.degen, out_degenerate);
            fail_count++;
          end
        end
      end
      rays_pending = ray_queue.size();
    end
  end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus for the camera ray direction unit
// Drives screen coordinates under several camera settings with random gaps
// and output backpressure; the checker predicts and compares every ray.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 56;
  localparam int MAX_CYCLE = 400000;
  localparam logic [crd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, out_degenerate;
  logic [crd_pkg::COORD_W-1:0] in_screen_x, in_screen_y;
  logic signed [crd_pkg::DIR_W-1:0] out_dir_x, out_dir_y, out_dir_z;
  logic cfg_we;
  logic [crd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [crd_pkg::VEC_W-1:0] cfg_wdata;
  int fail_count, rays_pending, rays_checked, degenerate_seen;
  int cycle_count = 0;
  bit rx_idle_on, rx_hold_req;

  camera_ray_direction_unit uut (.*);
  ray_direction_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        hold = 0;
        while (hold < 200) begin
          out_stall <= 1'b1;
          @(negedge clk);
          hold++;
        end
        rx_hold_req = 1'b0;
      end
      out_stall <= rx_idle_on ? ($urandom_range(99) < 33) : 1'b0;
    end
  end

  task automatic write_reg(logic [crd_pkg::CFG_IDX_W-1:0] idx,
                           logic [crd_pkg::VEC_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one coordinate, hold until accepted
  task automatic send_coord(logic [crd_pkg::COORD_W-1:0] sx,
                            logic [crd_pkg::COORD_W-1:0] sy, bit gaps);
    while (gaps && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_screen_x <= sx;
    in_screen_y <= sy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    while (rays_pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [crd_pkg::VEC_W-1:0] rand_vec();
    return {16'($urandom_range(65535)), 16'($urandom_range(65535)),
            16'($urandom_range(65535))};
  endfunction

  function automatic logic [crd_pkg::VEC_W-1:0] small_vec();
    logic [crd_pkg::VEC_W-1:0] v;
    for (int i = 0; i < 3; i++)
      v[i*16 +: 16] = 16'($signed($urandom_range(16384)) - 8192);
    return v;
  endfunction

  initial begin
    bit gaps;
    in_valid = 1'b0;
    in_screen_x = '0;
    in_screen_y = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rx_idle_on = 1'b0;
    rx_hold_req = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: corners, center and an interior point at reset camera
    send_coord(16'h0000, 16'h0000, 0);
    send_coord(16'hFFFF, 16'hFFFF, 0);
    send_coord(16'h8000, 16'h8000, 0);
    send_coord(16'h0000, 16'hFFFF, 0);
    send_coord(16'hFFFF, 16'h0000, 0);
    send_coord(16'h5555, 16'hAAAA, 0);
    drain();

    // Zero extents and zero forward: center gives a degenerate ray
    write_reg(crd_pkg::CFG_HALF_W, '0);
    write_reg(crd_pkg::CFG_HALF_H, '0);
    send_coord(16'h1234, 16'hFEDC, 0);
    drain();
    write_reg(crd_pkg::CFG_FORWARD, '0);
    send_coord(16'h0000, 16'hFFFF, 0);
    drain();
    write_reg(crd_pkg::CFG_HALF_W, 16'hFFFF);
    write_reg(crd_pkg::CFG_HALF_H, 16'hFFFF);
    send_coord(16'h8000, 16'h8000, 0);
    send_coord(16'h0000, 16'h0000, 0);
    send_coord(16'hFFFF, 16'hFFFF, 0);
    drain();
    // Extreme basis: right components most negative, up most positive, forward mixed
    write_reg(crd_pkg::CFG_RIGHT, 48'h8000_8000_8000);
    write_reg(crd_pkg::CFG_UP, 48'h7FFF_7FFF_7FFF);
    write_reg(crd_pkg::CFG_FORWARD, 48'h8000_7FFF_FFFF);
    send_coord(16'h0000, 16'h0000, 0);
    send_coord(16'hFFFF, 16'hFFFF, 0);
    send_coord(16'h0000, 16'hFFFF, 0);
    send_coord(16'h7FFF, 16'h8001, 0);
    drain();
    // Register index beyond the list is ignored
    write_reg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
    send_coord(16'h4000, 16'hC000, 0);
    drain();

    // Random phases, each under its own camera setting
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 3)
        0: begin
          write_reg(crd_pkg::CFG_RIGHT, rand_vec());
          write_reg(crd_pkg::CFG_UP, rand_vec());
          write_reg(crd_pkg::CFG_FORWARD, rand_vec());
        end
        1: begin
          write_reg(crd_pkg::CFG_RIGHT, small_vec());
          write_reg(crd_pkg::CFG_UP, small_vec());
          write_reg(crd_pkg::CFG_FORWARD, small_vec());
        end
        default: begin
          write_reg(crd_pkg::CFG_RIGHT, crd_pkg::RST_RIGHT);
          write_reg(crd_pkg::CFG_UP, crd_pkg::RST_UP);
          write_reg(crd_pkg::CFG_FORWARD, crd_pkg::RST_FORWARD);
        end
      endcase
      write_reg(crd_pkg::CFG_HALF_W, (ph == 4) ? 16'd0 : 16'($urandom_range(65535)));
      write_reg(crd_pkg::CFG_HALF_H, (ph == 7) ? 16'hFFFF : 16'($urandom_range(65535)));
      gaps = (ph != 2);
      rx_idle_on = (ph != 2);
      if (ph == 5) rx_hold_req = 1'b1;
      for (int n = 0; n < 93; n++)
        send_coord(16'($urandom_range(65535)), 16'($urandom_range(65535)), gaps);
      drain();
    end

    rx_idle_on = 1'b0;
    $display("Checked %0d rays (%0d degenerate) over directed corners and 10 camera settings.",
             rays_checked, degenerate_seen);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
